FILE: rtl/dhp_pkg.sv
// ----------------------------------------------------------------------------
// dhp_pkg
// Shared constants, types and codes of the display head placement core.
// ----------------------------------------------------------------------------
`default_nettype none

package dhp_pkg;

	// Table size and coordinate width.
	localparam int MAX_HEADS = 8;
	localparam int COORD_W   = 16;

	// Derived widths.
	localparam int IDX_W  = $clog2(MAX_HEADS);
	localparam int CNT_W  = $clog2(MAX_HEADS + 1);
	localparam int AREA_W = 2 * COORD_W;
	localparam int TOT_W  = AREA_W + IDX_W;

	// Fixed field widths of the ports.
	localparam int HEAD_W   = 3;
	localparam int FUNC_W   = 2;
	localparam int HCOUNT_W = 4;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	// One head rectangle, also used for the query rectangle.
	typedef struct packed {
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] top;
		logic [COORD_W-1:0]        width;
		logic [COORD_W-1:0]        height;
	} box_t;

	// Function codes of an input word.
	typedef enum logic [FUNC_W-1:0] {
		FN_LOAD  = 2'd0,
		FN_RECT  = 2'd1,
		FN_POINT = 2'd2
	} func_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEAD_COUNT = 2'd0,
		REG_PRIMARY    = 2'd1,
		REG_SCREEN_W   = 2'd2,
		REG_SCREEN_H   = 2'd3
	} reg_t;

endpackage

`default_nettype wire

FILE: rtl/dhp_table.sv
// ----------------------------------------------------------------------------
// dhp_table
// Head rectangle memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module dhp_table import dhp_pkg::*; (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  box_t             wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output box_t             rd_data
);

	box_t mem [MAX_HEADS];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the data is registered and shows in the cycle after rd_en.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/dhp_overlap.sv
// ----------------------------------------------------------------------------
// dhp_overlap
// Two-stage overlap unit: clipped spans in the first stage, their product
// (the overlap area) in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module dhp_overlap import dhp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [IDX_W-1:0]  in_idx,
	input  box_t              rect,
	input  box_t              box,
	output logic              vld_s2,
	output logic [IDX_W-1:0]  idx_s2,
	output logic [AREA_W-1:0] area_s2
);

	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [COORD_W-1:0] span_x_s1;
	logic [COORD_W-1:0] span_y_s1;

	// Length of the intersection of two intervals, zero when they miss.
	function automatic logic [COORD_W-1:0] span_len(
		input logic signed [COORD_W-1:0] a0,
		input logic [COORD_W-1:0]        alen,
		input logic signed [COORD_W-1:0] b0,
		input logic [COORD_W-1:0]        blen
	);
		logic signed [COORD_W+1:0] sa;
		logic signed [COORD_W+1:0] sb;
		logic signed [COORD_W+1:0] ea;
		logic signed [COORD_W+1:0] eb;
		logic signed [COORD_W+1:0] lo;
		logic signed [COORD_W+1:0] hi;
		logic signed [COORD_W+1:0] d;
		sa = $signed({{2{a0[COORD_W-1]}}, a0});
		sb = $signed({{2{b0[COORD_W-1]}}, b0});
		ea = sa + $signed({2'b00, alen});
		eb = sb + $signed({2'b00, blen});
		lo = (sa > sb) ? sa : sb;
		hi = (ea < eb) ? ea : eb;
		d  = hi - lo;
		return (d > 0) ? d[COORD_W-1:0] : '0;
	endfunction

	// Control tags of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 1: clipped spans on both axes.
	always_ff @(posedge clk) begin
		idx_s1    <= in_idx;
		span_x_s1 <= span_len(rect.left, rect.width, box.left, box.width);
		span_y_s1 <= span_len(rect.top, rect.height, box.top, box.height);
	end

	// Stage 2: overlap area.
	always_ff @(posedge clk) begin
		idx_s2  <= idx_s1;
		area_s2 <= AREA_W'(span_x_s1) * AREA_W'(span_y_s1);
	end

endmodule

`default_nettype wire

FILE: rtl/display_head_placement_core.sv
// ----------------------------------------------------------------------------
// display_head_placement_core
// Keeps a table of head rectangles and answers rectangle placement and
// pointer lookup queries against it.
//
//   channel  | signals                                    | direction
//   ---------+--------------------------------------------+----------
//   command  | start, busy, func .. pointer_valid         | in, busy out
//   result   | done, head, dead_flag, partial_flag,       | out
//            | multiple_flag                              |
//   config   | cfg_we, cfg_idx, cfg_data                  | in
//
// A load word does not make the core busy and writes the table at the
// accepting edge. A query keeps the core busy until its result is shown,
// and a rectangle that overlaps no head among several adds a pointer pass.
// The table has a single read port: one entry is read per cycle and fed
// through the two-stage overlap unit. Reset clears the configuration
// registers and the control state; the table is not cleared and must be
// loaded before it is read. The result is shown with done for one cycle
// and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module display_head_placement_core import dhp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// Command channel
	input  logic                      start,
	output logic                      busy,
	input  logic [FUNC_W-1:0]         func,
	input  logic [IDX_W-1:0]          entry_index,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic [COORD_W-1:0]        size_w,
	input  logic [COORD_W-1:0]        size_h,
	input  logic signed [COORD_W-1:0] pointer_x,
	input  logic signed [COORD_W-1:0] pointer_y,
	input  logic                      pointer_valid,
	// Result channel
	output logic                      done,
	output logic [HEAD_W-1:0]         head,
	output logic                      dead_flag,
	output logic                      partial_flag,
	output logic                      multiple_flag,
	// Configuration port
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_idx,
	input  logic [CFG_W-1:0]          cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_DECIDE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [HCOUNT_W-1:0] head_count_q;
	logic [HEAD_W-1:0]   primary_q;
	logic [COORD_W-1:0]  screen_w_q;
	logic [COORD_W-1:0]  screen_h_q;

	// Query latched at acceptance.
	box_t                      rect_q;
	logic signed [COORD_W-1:0] ptr_x_q;
	logic signed [COORD_W-1:0] ptr_y_q;
	logic                      ptr_vld_q;
	logic                      is_rect_q;
	logic [AREA_W-1:0]         rarea_q;

	// Sequencer.
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] len_q;
	logic             dly_q;
	logic             pmode_q;
	logic             single_q;

	// Result registers.
	logic              done_q;
	logic [HEAD_W-1:0] head_q;
	logic              dead_q;
	logic              partial_q;
	logic              multiple_q;

	// Accumulators.
	logic              found_q;
	logic              mult_q;
	logic [AREA_W-1:0] best_q;
	logic [IDX_W-1:0]  bidx_q;
	logic [TOT_W-1:0]  total_q;
	logic              phit_q;
	logic [IDX_W-1:0]  pidx_q;

	// Datapath signals.
	logic              accept;
	logic [CNT_W-1:0]  n_used;
	logic              issue;
	logic              iss_s1;
	logic [IDX_W-1:0]  idx_s1;
	box_t              wr_box;
	box_t              rd_box;
	box_t              ovl_box;
	logic              ovl_vld;
	logic [IDX_W-1:0]  ovl_idx;
	logic [AREA_W-1:0] ovl_area;
	logic signed [COORD_W:0] dx;
	logic signed [COORD_W:0] dy;
	logic              pt_hit;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// Number of heads in use, limited to the table size.
	assign n_used = (int'(head_count_q) > MAX_HEADS) ? CNT_W'(MAX_HEADS)
	                                                 : CNT_W'(head_count_q);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_count_q <= '0;
			primary_q    <= '0;
			screen_w_q   <= '0;
			screen_h_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_HEAD_COUNT: head_count_q <= cfg_data[HCOUNT_W-1:0];
				REG_PRIMARY:    primary_q    <= cfg_data[HEAD_W-1:0];
				REG_SCREEN_W:   screen_w_q   <= cfg_data[COORD_W-1:0];
				REG_SCREEN_H:   screen_h_q   <= cfg_data[COORD_W-1:0];
				default:        ;
			endcase
		end
	end

	// Query fields and rectangle area, captured when a word is accepted.
	always_ff @(posedge clk) begin
		if (accept) begin
			rect_q.left   <= pos_x;
			rect_q.top    <= pos_y;
			rect_q.width  <= size_w;
			rect_q.height <= size_h;
			ptr_x_q       <= pointer_x;
			ptr_y_q       <= pointer_y;
			ptr_vld_q     <= pointer_valid;
			is_rect_q     <= (func == FN_RECT);
			rarea_q       <= AREA_W'(size_w) * AREA_W'(size_h);
		end
	end

	// Head table, written by load words.
	assign wr_box.left   = pos_x;
	assign wr_box.top    = pos_y;
	assign wr_box.width  = size_w;
	assign wr_box.height = size_h;

	assign issue = (state_q == ST_SCAN) && (cnt_q != len_q);

	dhp_table u_table (
		.clk     (clk),
		.wr_en   (accept && (func == FN_LOAD)),
		.wr_addr (entry_index),
		.wr_data (wr_box),
		.rd_en   (issue),
		.rd_addr (cnt_q[IDX_W-1:0]),
		.rd_data (rd_box)
	);

	// Tag of the entry whose data leaves the table this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= 1'b0;
		end else begin
			iss_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IDX_W-1:0];
	end

	// With at most one head the whole screen stands in for the table entry.
	always_comb begin
		if (single_q) begin
			ovl_box.left   = '0;
			ovl_box.top    = '0;
			ovl_box.width  = screen_w_q;
			ovl_box.height = screen_h_q;
		end else begin
			ovl_box = rd_box;
		end
	end

	dhp_overlap u_overlap (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (iss_s1 && !pmode_q),
		.in_idx  (idx_s1),
		.rect    (rect_q),
		.box     (ovl_box),
		.vld_s2  (ovl_vld),
		.idx_s2  (ovl_idx),
		.area_s2 (ovl_area)
	);

	// Pointer inside the entry just read.
	assign dx = $signed({ptr_x_q[COORD_W-1], ptr_x_q})
	          - $signed({rd_box.left[COORD_W-1], rd_box.left});
	assign dy = $signed({ptr_y_q[COORD_W-1], ptr_y_q})
	          - $signed({rd_box.top[COORD_W-1], rd_box.top});
	assign pt_hit = iss_s1 && pmode_q
	             && !dx[COORD_W] && (dx[COORD_W-1:0] < rd_box.width)
	             && !dy[COORD_W] && (dy[COORD_W-1:0] < rd_box.height);

	// Best overlap, overlap sum and first pointer hit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			mult_q  <= 1'b0;
			best_q  <= '0;
			bidx_q  <= '0;
			total_q <= '0;
			phit_q  <= 1'b0;
			pidx_q  <= '0;
		end else if (accept) begin
			found_q <= 1'b0;
			mult_q  <= 1'b0;
			best_q  <= '0;
			bidx_q  <= '0;
			total_q <= '0;
			phit_q  <= 1'b0;
			pidx_q  <= '0;
		end else begin
			if (ovl_vld) begin
				total_q <= total_q + TOT_W'(ovl_area);
				if (ovl_area > best_q) begin
					if (found_q) begin
						mult_q <= 1'b1;
					end
					found_q <= 1'b1;
					best_q  <= ovl_area;
					bidx_q  <= ovl_idx;
				end
			end
			if (pt_hit && !phit_q) begin
				phit_q <= 1'b1;
				pidx_q <= idx_s1;
			end
		end
	end

	// Sequencer and result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			len_q      <= '0;
			dly_q      <= 1'b0;
			pmode_q    <= 1'b0;
			single_q   <= 1'b0;
			done_q     <= 1'b0;
			head_q     <= '0;
			dead_q     <= 1'b0;
			partial_q  <= 1'b0;
			multiple_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (func == FN_RECT)) begin
						state_q  <= ST_SCAN;
						cnt_q    <= '0;
						pmode_q  <= 1'b0;
						single_q <= (n_used <= CNT_W'(1));
						len_q    <= (n_used <= CNT_W'(1)) ? CNT_W'(1) : n_used;
					end else if (accept && (func == FN_POINT)) begin
						state_q  <= ST_SCAN;
						cnt_q    <= '0;
						pmode_q  <= 1'b1;
						single_q <= 1'b0;
						len_q    <= pointer_valid ? n_used : '0;
					end
				end
				ST_SCAN: begin
					if (cnt_q == len_q) begin
						state_q <= ST_WAIT;
						dly_q   <= 1'b0;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_WAIT: begin
					// Let the last entry pass through the overlap unit.
					if (dly_q) begin
						state_q <= ST_DECIDE;
					end else begin
						dly_q <= 1'b1;
					end
				end
				ST_DECIDE: begin
					if (pmode_q) begin
						// Pointer lookup finished.
						state_q    <= ST_IDLE;
						done_q     <= 1'b1;
						head_q     <= phit_q ? HEAD_W'(pidx_q) : primary_q;
						dead_q     <= is_rect_q;
						partial_q  <= 1'b0;
						multiple_q <= 1'b0;
					end else if (found_q || single_q) begin
						state_q    <= ST_IDLE;
						done_q     <= 1'b1;
						head_q     <= single_q ? primary_q : HEAD_W'(bidx_q);
						dead_q     <= !found_q;
						partial_q  <= found_q && (total_q != TOT_W'(rarea_q));
						multiple_q <= mult_q;
					end else begin
						// Dead rectangle among several heads: look up the pointer.
						state_q <= ST_SCAN;
						cnt_q   <= '0;
						pmode_q <= 1'b1;
						len_q   <= ptr_vld_q ? n_used : '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done          = done_q;
	assign head          = head_q;
	assign dead_flag     = dead_q;
	assign partial_flag  = partial_q;
	assign multiple_flag = multiple_q;

	// A result word only follows the decision step.
	a_done_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_DECIDE))
		else $error("result word without a decision step");

	// An accepted query keeps the core busy in the next cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ((func == FN_RECT) || (func == FN_POINT))) |=> busy)
		else $error("accepted query did not start a scan");

	// A dead rectangle is never partial or multiple.
	a_dead_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && dead_q) |-> (!partial_q && !multiple_q))
		else $error("dead result carries partial or multiple flag");

	// The scan counter never runs past its length.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q <= len_q))
		else $error("scan counter beyond scan length");

	// The overlap unit only carries words of a rectangle pass.
	a_ovl_mode: assert property (@(posedge clk) disable iff (!arst_n)
		ovl_vld |-> (!pmode_q && (state_q != ST_IDLE)))
		else $error("overlap result outside a rectangle pass");

endmodule

`default_nettype wire

FILE: verif/tb_display_head_placement_core.sv
// ----------------------------------------------------------------------------
// tb_display_head_placement_core
// Self-checking bench for the display head placement core. A queue of command
// words feeds a clocked driver that offers each word on start and waits for
// busy to drop. A local model of the head table and the registers predicts
// every rectangle and point answer at the accepting edge. A monitor compares
// each done strobe with the oldest prediction. Directed words come first, then
// phases of random layouts and queries under changing register settings.
// ----------------------------------------------------------------------------
module tb_display_head_placement_core;
	import dhp_pkg::*;

	// The command code that the block must ignore.
	localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

	localparam int PHASES           = 14;
	localparam int RANDOM_PER_PHASE = 80;
	localparam int SETTLE_CYCLES    = 40;
	localparam int CYCLE_LIMIT      = 400000;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} spot_t;

	typedef struct {
		logic [FUNC_W-1:0] fn;
		logic [IDX_W-1:0]  slot;
		box_t              box;
		spot_t             ptr;
		logic              ptr_ok;
	} command_t;

	typedef struct packed {
		logic [HEAD_W-1:0] head;
		logic              dead;
		logic              partial;
		logic              multiple;
	} placement_t;

	logic clk;
	logic arst_n = 1'b0;

	// Block inputs start at known values.
	logic                      start = 1'b0;
	logic [FUNC_W-1:0]         func = '0;
	logic [IDX_W-1:0]          entry_index = '0;
	logic signed [COORD_W-1:0] pos_x = '0;
	logic signed [COORD_W-1:0] pos_y = '0;
	logic [COORD_W-1:0]        size_w = '0;
	logic [COORD_W-1:0]        size_h = '0;
	logic signed [COORD_W-1:0] pointer_x = '0;
	logic signed [COORD_W-1:0] pointer_y = '0;
	logic                      pointer_valid = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_idx = '0;
	logic [CFG_W-1:0]          cfg_data = '0;

	logic                      busy;
	logic                      done;
	logic [HEAD_W-1:0]         head;
	logic                      dead_flag;
	logic                      partial_flag;
	logic                      multiple_flag;

	// Shadow of the registers and of the head table as the block sees them.
	logic [HCOUNT_W-1:0] cfg_heads = '0;
	logic [HEAD_W-1:0]   cfg_primary = '0;
	logic [COORD_W-1:0]  cfg_scr_w = '0;
	logic [COORD_W-1:0]  cfg_scr_h = '0;
	box_t                head_box [MAX_HEADS];

	// Table contents as planned by the stimulus, ahead of acceptance.
	box_t                plan_box [MAX_HEADS];

	command_t            command_backlog [$];
	placement_t          placement_due [$];

	int gap_odds = 4;
	int gap_left = 0;
	int fail_count = 0;
	int results_checked = 0;
	int n_loads = 0;
	int n_rects = 0;
	int n_points = 0;
	int n_ignored = 0;
	int n_settings = 0;
	int cycles = 0;

	display_head_placement_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.entry_index   (entry_index),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.size_w        (size_w),
		.size_h        (size_h),
		.pointer_x     (pointer_x),
		.pointer_y     (pointer_y),
		.pointer_valid (pointer_valid),
		.done          (done),
		.head          (head),
		.dead_flag     (dead_flag),
		.partial_flag  (partial_flag),
		.multiple_flag (multiple_flag),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Length of the common part of two intervals, never negative.
	function automatic longint span_len(longint a0, longint alen, longint b0, longint blen);
		longint lo;
		longint hi;
		lo = (a0 > b0) ? a0 : b0;
		hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
		return (hi > lo) ? hi - lo : 0;
	endfunction

	function automatic longint overlap_area(box_t r, box_t b);
		return span_len($signed(r.left), r.width, $signed(b.left), b.width) *
			span_len($signed(r.top), r.height, $signed(b.top), b.height);
	endfunction

	// First active head that contains the pointer, else the primary head.
	function automatic logic [HEAD_W-1:0] head_under_pointer(command_t c, int live);
		longint dx;
		longint dy;
		int i;
		if (live == 0 || !c.ptr_ok)
			return cfg_primary;
		for (i = 0; i < live; i++) begin
			dx = longint'($signed(c.ptr.x)) - longint'($signed(head_box[i].left));
			dy = longint'($signed(c.ptr.y)) - longint'($signed(head_box[i].top));
			if (dx >= 0 && dx < longint'(head_box[i].width) &&
				dy >= 0 && dy < longint'(head_box[i].height))
				return i[HEAD_W-1:0];
		end
		return cfg_primary;
	endfunction

	// Expected answer of a rectangle or point query.
	function automatic placement_t predict_placement(command_t c);
		placement_t p;
		box_t       screen;
		longint     rect_area;
		longint     a;
		longint     best;
		longint     total;
		int         live;
		int         i;
		bit         found;
		p = '0;
		live = (cfg_heads > MAX_HEADS) ? MAX_HEADS : int'(cfg_heads);
		if (c.fn == FN_POINT) begin
			p.head = head_under_pointer(c, live);
			return p;
		end
		rect_area = longint'(c.box.width) * longint'(c.box.height);
		// With at most one head the whole screen stands in for the table.
		if (live <= 1) begin
			screen = '{16'sd0, 16'sd0, cfg_scr_w, cfg_scr_h};
			a = overlap_area(c.box, screen);
			p.head = cfg_primary;
			if (a == 0)
				p.dead = 1'b1;
			else if (a != rect_area)
				p.partial = 1'b1;
			return p;
		end
		found = 1'b0;
		best = 0;
		total = 0;
		for (i = 0; i < live; i++) begin
			a = overlap_area(c.box, head_box[i]);
			total += a;
			if (a > best) begin
				if (found)
					p.multiple = 1'b1;
				found = 1'b1;
				best = a;
				p.head = i[HEAD_W-1:0];
			end
		end
		if (!found) begin
			p.dead = 1'b1;
			p.head = head_under_pointer(c, live);
		end else if (total != rect_area) begin
			p.partial = 1'b1;
		end
		return p;
	endfunction

	function automatic logic signed [COORD_W-1:0] clamp_coord(int v);
		if (v > 32767)
			return 16'h7fff;
		if (v < -32768)
			return 16'h8000;
		return v[COORD_W-1:0];
	endfunction

	function automatic logic [COORD_W-1:0] clamp_size(int v);
		if (v > 65535)
			return 16'hffff;
		if (v < 0)
			return '0;
		return v[COORD_W-1:0];
	endfunction

	function automatic box_t mk_box(int l, int t, int w, int h);
		return '{clamp_coord(l), clamp_coord(t), clamp_size(w), clamp_size(h)};
	endfunction

	function automatic spot_t mk_spot(int x, int y);
		return '{clamp_coord(x), clamp_coord(y)};
	endfunction

	// A rectangle around a box, up to scale times its size.
	function automatic box_t box_near(box_t b, int scale);
		int bw;
		int bh;
		bw = (b.width == 0) ? 8 : int'(b.width) * scale;
		bh = (b.height == 0) ? 8 : int'(b.height) * scale;
		return mk_box(int'($signed(b.left)) - bw / 2 + int'($urandom_range(0, bw)),
			int'($signed(b.top)) - bh / 2 + int'($urandom_range(0, bh)),
			$urandom_range(0, bw), $urandom_range(0, bh));
	endfunction

	// A point inside a box, or on its corner when the box is empty.
	function automatic spot_t spot_in(box_t b);
		int dx;
		int dy;
		dx = (b.width == 0) ? 0 : int'($urandom_range(0, int'(b.width) - 1));
		dy = (b.height == 0) ? 0 : int'($urandom_range(0, int'(b.height) - 1));
		return mk_spot(int'($signed(b.left)) + dx, int'($signed(b.top)) + dy);
	endfunction

	task automatic queue_cmd(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] slot, box_t b,
		spot_t sp, logic ok);
		command_t c;
		c = '{fn, slot, b, sp, ok};
		if (fn == FN_LOAD)
			plan_box[slot] = b;
		command_backlog.push_back(c);
	endtask

	// Registers change only while no word is in flight.
	task automatic write_reg(reg_t r, logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= r;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (r)
			REG_HEAD_COUNT: cfg_heads = v[HCOUNT_W-1:0];
			REG_PRIMARY:    cfg_primary = v[HEAD_W-1:0];
			REG_SCREEN_W:   cfg_scr_w = v;
			REG_SCREEN_H:   cfg_scr_h = v;
			default: ;
		endcase
	endtask

	// Wait for every word to be taken and answered, then let the block finish.
	task automatic wait_drained();
		while (command_backlog.size() != 0 || placement_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic report_mismatch(string msg);
		fail_count++;
		if (fail_count <= 40)
			$display("MISMATCH at cycle %0d, result %0d: %s", cycles, results_checked, msg);
	endtask

	// Driver: offer the oldest queued word, keep it up until busy drops.
	always @(posedge clk) begin
		command_t c;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				c = command_backlog.pop_front();
				case (c.fn)
					FN_LOAD: begin
						head_box[c.slot] = c.box;
						n_loads++;
					end
					FN_RECT: begin
						placement_due.push_back(predict_placement(c));
						n_rects++;
					end
					FN_POINT: begin
						placement_due.push_back(predict_placement(c));
						n_points++;
					end
					default: n_ignored++;
				endcase
				if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
					gap_left = $urandom_range(1, 13);
			end
			if (start && busy) begin
				// The offered word waits for busy to drop.
			end else if (gap_left != 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (command_backlog.size() != 0) begin
				c = command_backlog[0];
				func <= c.fn;
				entry_index <= c.slot;
				pos_x <= c.box.left;
				pos_y <= c.box.top;
				size_w <= c.box.width;
				size_h <= c.box.height;
				pointer_x <= c.ptr.x;
				pointer_y <= c.ptr.y;
				pointer_valid <= c.ptr_ok;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every done strobe carries one result word.
	always @(posedge clk) begin
		placement_t want;
		if (arst_n && done) begin
			if (placement_due.size() == 0) begin
				report_mismatch($sformatf("result word with nothing pending, head %0d", head));
			end else begin
				want = placement_due.pop_front();
				if (head !== want.head)
					report_mismatch($sformatf("head %0d, expected %0d", head, want.head));
				if (dead_flag !== want.dead)
					report_mismatch($sformatf("dead_flag %b, expected %b", dead_flag,
						want.dead));
				if (partial_flag !== want.partial)
					report_mismatch($sformatf("partial_flag %b, expected %b", partial_flag,
						want.partial));
				if (multiple_flag !== want.multiple)
					report_mismatch($sformatf("multiple_flag %b, expected %b",
						multiple_flag, want.multiple));
				results_checked++;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_display_head_placement_core: errors");
			$finish;
		end
	end

	initial begin
		static int  heads_plan [PHASES] = '{8, 0, 1, 2, 8, 3, 4, 5, 6, 7, 1, 8, 0, 8};
		int         p;
		int         k;
		int         s;
		int         r;
		int         kind;
		int         live;
		int         x;
		int         y;
		int         w;
		int         h;
		logic       ok;
		box_t       b;
		box_t       anchor;
		spot_t      sp;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Single-head rules against a 1920 by 1080 screen.
		write_reg(REG_PRIMARY, 5);
		write_reg(REG_SCREEN_W, 1920);
		write_reg(REG_SCREEN_H, 1080);
		n_settings++;
		for (s = 0; s < 6; s++)
			queue_cmd(FN_LOAD, s, mk_box(s * 1600, 0, 1600, 1200), '0, 1'b0);
		queue_cmd(FN_LOAD, 6, '{16'h8000, 16'h8000, 16'h0000, 16'h0000}, '0, 1'b0);
		queue_cmd(FN_LOAD, 7, '{16'h7fff, 16'h7fff, 16'hffff, 16'hffff}, '0, 1'b0);
		queue_cmd(FN_RECT, 0, mk_box(100, 100, 800, 600), '0, 1'b0);
		queue_cmd(FN_RECT, 0, mk_box(1800, 1000, 400, 400), '0, 1'b0);
		queue_cmd(FN_RECT, 0, mk_box(3000, 0, 100, 100), '0, 1'b0);
		queue_cmd(FN_RECT, 0, mk_box(10, 10, 0, 500), '0, 1'b1);
		queue_cmd(FN_POINT, 0, '0, mk_spot(3300, 600), 1'b1);
		queue_cmd(FN_SPARE, 7, mk_box(100, 100, 10, 10), mk_spot(5, 5), 1'b1);
		wait_drained();

		// Eight heads: plain hit, a later head taking over, dead space fallbacks.
		write_reg(REG_HEAD_COUNT, 8);
		n_settings++;
		queue_cmd(FN_RECT, 0, mk_box(1700, 10, 100, 100), '0, 1'b0);
		queue_cmd(FN_RECT, 0, mk_box(1500, 100, 300, 200), '0, 1'b0);
		queue_cmd(FN_RECT, 0, mk_box(1400, 100, 300, 200), '0, 1'b0);
		queue_cmd(FN_RECT, 0, mk_box(0, -5000, 100, 100), mk_spot(3300, 600), 1'b1);
		queue_cmd(FN_RECT, 0, mk_box(0, -5000, 100, 100), mk_spot(3300, 600), 1'b0);
		queue_cmd(FN_RECT, 0, mk_box(0, -5000, 100, 100), mk_spot(-100, -100), 1'b1);
		queue_cmd(FN_POINT, 0, '0, mk_spot(5000, 10), 1'b1);
		queue_cmd(FN_POINT, 0, '0, mk_spot(5000, 10), 1'b0);
		queue_cmd(FN_RECT, 0, '{16'h8000, 16'h8000, 16'hffff, 16'hffff}, '0, 1'b0);
		queue_cmd(FN_SPARE, 0, '0, '0, 1'b0);
		queue_cmd(FN_POINT, 0, '0, '{16'h7fff, 16'h7fff}, 1'b1);
		wait_drained();

		for (p = 0; p < PHASES; p++) begin
			// The last phases run back to back; earlier ones idle at a random rate.
			if (p >= PHASES - 2)
				gap_odds = 0;
			else
				gap_odds = ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(1, 3));

			write_reg(REG_HEAD_COUNT, CFG_W'(heads_plan[p]));
			write_reg(REG_PRIMARY, (p == 0) ? CFG_W'(0) :
				(p == 1) ? CFG_W'(7) : CFG_W'($urandom_range(0, 7)));
			if (p == 1) begin
				write_reg(REG_SCREEN_W, 16'hffff);
				write_reg(REG_SCREEN_H, 16'hffff);
			end else if (p == 2) begin
				write_reg(REG_SCREEN_W, 0);
				write_reg(REG_SCREEN_H, 0);
			end else if (p == 10) begin
				write_reg(REG_SCREEN_W, 0);
				write_reg(REG_SCREEN_H, 16'hffff);
			end else begin
				write_reg(REG_SCREEN_W, CFG_W'($urandom_range(1, 4000)));
				write_reg(REG_SCREEN_H, CFG_W'($urandom_range(1, 3000)));
			end
			n_settings++;

			// New layout: a row, a two by four grid, a random pile, or anything.
			kind = $urandom_range(0, 9);
			x = int'($urandom_range(0, 6000)) - 3000;
			y = int'($urandom_range(0, 6000)) - 3000;
			w = $urandom_range(200, 2000);
			h = $urandom_range(200, 2000);
			for (s = 0; s < MAX_HEADS; s++) begin
				if (kind < 4) begin
					w = $urandom_range(200, 2000);
					b = mk_box(x, y + int'($urandom_range(0, 200)) - 100, w,
						$urandom_range(200, 2000));
					x += w;
				end else if (kind < 7) begin
					b = mk_box(x + (s % 4) * w, y + (s / 4) * h, w, h);
				end else if (kind < 9) begin
					b = mk_box(int'($urandom_range(0, 8000)) - 4000,
						int'($urandom_range(0, 8000)) - 4000,
						$urandom_range(0, 3000), $urandom_range(0, 3000));
				end else begin
					b = {$urandom, $urandom};
				end
				queue_cmd(FN_LOAD, s, b, $urandom, $urandom_range(0, 1));
			end

			live = (cfg_heads > MAX_HEADS) ? MAX_HEADS : int'(cfg_heads);
			for (k = 0; k < RANDOM_PER_PHASE; k++) begin
				r = $urandom_range(0, 99);
				if (live <= 1)
					anchor = '{16'sd0, 16'sd0, cfg_scr_w, cfg_scr_h};
				else
					anchor = plan_box[$urandom_range(0, live - 1)];
				sp = spot_in(plan_box[$urandom_range(0, MAX_HEADS - 1)]);
				ok = ($urandom_range(0, 9) != 0);
				if (r < 8) begin
					// Reload one entry in place.
					b = (r < 2) ? box_t'({$urandom, $urandom}) :
						box_near(plan_box[$urandom_range(0, MAX_HEADS - 1)], 1);
					queue_cmd(FN_LOAD, $urandom_range(0, 7), b, sp, ok);
				end else if (r < 10) begin
					queue_cmd(FN_SPARE, $urandom_range(0, 7), {$urandom, $urandom}, $urandom,
						$urandom_range(0, 1));
				end else if (r < 20) begin
					// Every field drawn over its full range.
					queue_cmd((r < 15) ? FN_RECT : FN_POINT, $urandom_range(0, 7),
						{$urandom, $urandom}, $urandom, $urandom_range(0, 1));
				end else if (r < 30) begin
					// A rectangle far above any ordinary layout.
					b = mk_box(int'($urandom_range(0, 65535)) - 32768,
						-32768 + int'($urandom_range(0, 6000)),
						$urandom_range(0, 3000), $urandom_range(0, 2000));
					if (r < 24)
						sp = $urandom;
					queue_cmd(FN_RECT, $urandom_range(0, 7), b, sp, ok);
				end else if (r < 75) begin
					queue_cmd(FN_RECT, $urandom_range(0, 7),
						box_near(anchor, $urandom_range(1, 4)), sp, ok);
				end else begin
					if (r >= 92)
						sp = $urandom;
					queue_cmd(FN_POINT, $urandom_range(0, 7), {$urandom, $urandom}, sp, ok);
				end
			end
			wait_drained();
		end

		$display("Run covered %0d loads, %0d rectangle and %0d point queries, %0d unused codes,",
			n_loads, n_rects, n_points, n_ignored);
		$display("over %0d register settings; %0d result words checked.", n_settings,
			results_checked);
		if (fail_count == 0) begin
			$display("tb_display_head_placement_core: clean");
		end else begin
			$display("tb_display_head_placement_core: errors");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/dhp_pkg.sv
rtl/dhp_table.sv
rtl/dhp_overlap.sv
rtl/display_head_placement_core.sv
verif/tb_display_head_placement_core.sv
